// ===== rtl/hbrs_pkg.sv =====
package hbrs_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int SIZE_W      = ADDR_W + 1;
	localparam int KEY_W       = 32;
	localparam int HINT_W      = 16;
	localparam int BOUND_W     = 12;
	localparam int STATUS_W    = 2;
	localparam int CMD_W       = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE  = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_ORDER = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WR_RD,
		S_WR_CHK,
		S_RD_RD,
		S_RD_CHK,
		S_LK_WIN,
		S_LK_RCUR,
		S_LK_RNXT,
		S_LK_EVAL,
		S_LK_REND,
		S_LK_FLAG,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [KEY_W-1:0]  wr_start;
		logic [KEY_W-1:0]  wr_end;
	} mem_req_t;

endpackage

// ===== rtl/hbrs_table.sv =====
module hbrs_table (
	input  logic                         clk,
	input  hbrs_pkg::mem_req_t           req,
	output logic [hbrs_pkg::KEY_W-1:0]   start_rd,
	output logic [hbrs_pkg::KEY_W-1:0]   end_rd
);
	import hbrs_pkg::*;

	logic [KEY_W-1:0] start_mem [TABLE_DEPTH];
	logic [KEY_W-1:0] end_mem   [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			start_mem[req.wr_addr] <= req.wr_start;
			end_mem[req.wr_addr]   <= req.wr_end;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			start_rd <= start_mem[req.rd_addr];
			end_rd   <= end_mem[req.rd_addr];
		end
	end

endmodule

// ===== rtl/hinted_bounded_range_search.sv =====
// Interval table with hinted, bounded bisection. Every item yields exactly one result item.
// A write or read passes a table read state and a check state before its result goes to
// the output register; a lookup passes window setup, R bisection rounds (1 to 12, at most
// floor(log2(error_bound)) + 1), an end read and a flag state. In each round the single
// table read port fetches start[p] and start[p+1] one after the other before the shared
// midpoint adder moves p. The input side stalls while an item is in progress.
// A finished result waits in its own output register, so the next item is accepted while
// it is still held. The size register may be written only while the block is idle.
module hinted_bounded_range_search (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [hbrs_pkg::CMD_W-1:0]      command,
	input  logic [hbrs_pkg::ADDR_W-1:0]     entry_address,
	input  logic [hbrs_pkg::KEY_W-1:0]      key_value,
	input  logic [hbrs_pkg::KEY_W-1:0]      end_value,
	input  logic [hbrs_pkg::HINT_W-1:0]     position_hint,
	input  logic [hbrs_pkg::BOUND_W-1:0]    error_bound,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [hbrs_pkg::ADDR_W-1:0]     found_position,
	output logic                            beyond_end,
	output logic [hbrs_pkg::KEY_W-1:0]      start_out,
	output logic [hbrs_pkg::KEY_W-1:0]      end_out,
	output logic [hbrs_pkg::STATUS_W-1:0]   status,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hbrs_pkg::SIZE_W-1:0]     cfg_data
);
	import hbrs_pkg::*;

	localparam int PROD_W = HINT_W + SIZE_W;

	state_t                state_q, state_d;
	logic [SIZE_W-1:0]     entries_q;
	logic [SIZE_W-1:0]     used_n;
	logic [ADDR_W-1:0]     last_idx;

	logic [ADDR_W-1:0]     addr_q;
	logic [KEY_W-1:0]      key_q;
	logic [KEY_W-1:0]      endv_q;
	logic [BOUND_W-1:0]    bound_q;
	logic [PROD_W-1:0]     prod_q;
	logic [ADDR_W-1:0]     pos_q, lo_q, hi_q;
	logic                  cur_q;

	logic [ADDR_W-1:0]     res_pos_q;
	logic                  res_beyond_q;
	logic [KEY_W-1:0]      res_start_q, res_end_q;
	logic [STATUS_W-1:0]   res_status_q;

	logic                  out_valid_q;
	logic [ADDR_W-1:0]     out_pos_q;
	logic                  out_beyond_q;
	logic [KEY_W-1:0]      out_start_q, out_end_q;
	logic [STATUS_W-1:0]   out_status_q;

	mem_req_t              mem_req;
	logic [KEY_W-1:0]      start_rd, end_rd;

	logic                  accept;
	logic                  out_free;
	logic                  nxt;
	logic                  stop_hit;
	logic                  last_round;
	logic [SIZE_W-1:0]     mid_sum;
	logic [SIZE_W-1:0]     mid_sum_up;
	logic [ADDR_W-1:0]     mid_pos;
	logic [ADDR_W-1:0]     win_pos;
	logic [SIZE_W-1:0]     win_hi;
	logic [ADDR_W-1:0]     win_lo;

	hbrs_table u_table (
		.clk      (clk),
		.req      (mem_req),
		.start_rd (start_rd),
		.end_rd   (end_rd)
	);

	// A size of zero counts as one entry, and sizes past the table saturate.
	always_comb begin
		if (entries_q == '0) begin
			used_n = SIZE_W'(1);
		end else if (entries_q > SIZE_W'(TABLE_DEPTH)) begin
			used_n = SIZE_W'(TABLE_DEPTH);
		end else begin
			used_n = entries_q;
		end
		last_idx = ADDR_W'(used_n - SIZE_W'(1));
	end

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= SIZE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			entries_q <= cfg_data;
		end
	end

	// Window setup from the registered product hint * n.
	always_comb begin
		win_pos = prod_q[PROD_W-1:HINT_W] > {1'b0, last_idx}
			? last_idx : ADDR_W'(prod_q[PROD_W-1:HINT_W]);
		win_hi  = {1'b0, win_pos} + {1'b0, bound_q};
		win_lo  = (win_pos > bound_q) ? (win_pos - bound_q) : '0;
	end

	// One shared adder forms the midpoint: ceiling toward hi, floor toward lo.
	always_comb begin
		nxt        = (pos_q == last_idx) || (start_rd > key_q);
		stop_hit   = cur_q && nxt;
		mid_sum    = {1'b0, pos_q} + {1'b0, (cur_q ? hi_q : lo_q)};
		mid_sum_up = mid_sum + SIZE_W'(cur_q);
		mid_pos    = mid_sum_up[SIZE_W-1:1];
		last_round = (bound_q[BOUND_W-1:1] == '0);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (command)
						CMD_WRITE:  state_d = S_WR_RD;
						CMD_LOOKUP: state_d = S_LK_WIN;
						CMD_READ:   state_d = S_RD_RD;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_WR_RD:   state_d = S_WR_CHK;
			S_WR_CHK:  state_d = S_DONE;
			S_RD_RD:   state_d = S_RD_CHK;
			S_RD_CHK:  state_d = S_DONE;
			S_LK_WIN:  state_d = S_LK_RCUR;
			S_LK_RCUR: state_d = S_LK_RNXT;
			S_LK_RNXT: state_d = S_LK_EVAL;
			S_LK_EVAL: state_d = (stop_hit || last_round) ? S_LK_REND : S_LK_RCUR;
			S_LK_REND: state_d = S_LK_FLAG;
			S_LK_FLAG: state_d = S_DONE;
			S_DONE:    state_d = out_free ? S_IDLE : S_DONE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_req          = '0;
		mem_req.wr_addr  = addr_q;
		mem_req.wr_start = key_q;
		mem_req.wr_end   = endv_q;
		mem_req.rd_addr  = pos_q;
		unique case (state_q)
			S_WR_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = addr_q - ADDR_W'(1);
			end
			S_WR_CHK: begin
				mem_req.wr_en = 1'b1;
			end
			S_RD_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = addr_q;
			end
			S_LK_RCUR, S_LK_REND: begin
				mem_req.rd_en = 1'b1;
			end
			S_LK_RNXT: begin
				// Past the last entry the start counts as infinite; the read is ignored.
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = pos_q + ADDR_W'(1);
			end
			default: begin
				mem_req.rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					addr_q       <= entry_address;
					key_q        <= key_value;
					endv_q       <= end_value;
					bound_q      <= error_bound;
					prod_q       <= PROD_W'(position_hint) * PROD_W'(used_n);
					res_pos_q    <= '0;
					res_beyond_q <= 1'b0;
					res_start_q  <= '0;
					res_end_q    <= '0;
					res_status_q <= ST_OK;
				end
			end
			S_WR_CHK: begin
				if (addr_q != '0 && key_q <= start_rd) begin
					res_status_q <= ST_ORDER;
				end
			end
			S_RD_CHK: begin
				if ({1'b0, addr_q} >= used_n) begin
					res_status_q <= ST_RANGE;
				end else begin
					res_start_q <= start_rd;
					res_end_q   <= end_rd;
				end
			end
			S_LK_WIN: begin
				pos_q <= win_pos;
				lo_q  <= win_lo;
				hi_q  <= (win_hi > {1'b0, last_idx}) ? last_idx : ADDR_W'(win_hi);
			end
			S_LK_RNXT: begin
				cur_q <= (start_rd <= key_q);
			end
			S_LK_EVAL: begin
				if (!stop_hit) begin
					if (cur_q) begin
						lo_q <= pos_q;
					end else begin
						hi_q <= pos_q;
					end
					pos_q   <= mid_pos;
					bound_q <= bound_q >> 1;
				end
			end
			S_LK_FLAG: begin
				res_pos_q    <= pos_q;
				res_beyond_q <= (end_rd < key_q);
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_pos_q    <= res_pos_q;
			out_beyond_q <= res_beyond_q;
			out_start_q  <= res_start_q;
			out_end_q    <= res_end_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign found_position = out_pos_q;
	assign beyond_end     = out_beyond_q;
	assign start_out      = out_start_q;
	assign end_out        = out_end_q;
	assign status         = out_status_q;

endmodule
